// ----- src/stpg_pkg.sv -----
// stpg_pkg.sv - shared types, constants and the sine table function for the
// sine tone PCM byte generator. No dependencies; front, fifo, back and top import it.
package stpg_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_INC    = 3'd0,
        REG_GAIN         = 3'd1,
        REG_CHANNELS     = 3'd2,
        REG_BYTES        = 3'd3,
        REG_SAMPLE_COUNT = 3'd4
    } cfg_reg_t;

    // Register field widths
    localparam int PHASE_INC_W = 32;
    localparam int GAIN_W      = 17;
    localparam int CHCFG_W     = 4;
    localparam int NBCFG_W     = 3;
    localparam int COUNT_W     = 24;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    // Frame shape
    localparam int MAX_CHANNELS = 8;
    localparam int MAX_BYTES    = 4;
    localparam int NCH_W        = 5;
    localparam int NB_W         = 3;
    localparam int BYTE_W       = 8;
    localparam int CH_IDX_W     = 3;
    localparam int BYTE_IDX_W   = 2;
    localparam int USER_W       = CH_IDX_W + BYTE_IDX_W + 1;

    // Datapath widths
    localparam int MAG_W       = 18;
    localparam int PROD_W      = 34;
    localparam int WIDE_W      = PROD_W + 31;
    localparam int SCALE_SHIFT = 33;
    localparam int SAMPLE_W    = 32;

    localparam longint unsigned SINE_ONE   = 64'd131072;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    // Frame queue between front and back
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PHASE_INC_W-1:0] phase_inc;
        logic [GAIN_W-1:0]      gain;
        logic [CHCFG_W-1:0]     channels;
        logic [NBCFG_W-1:0]     bytes;
        logic [COUNT_W-1:0]     sample_count;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [NCH_W-1:0]    nch;
        logic [NB_W-1:0]     nb;
        logic                done;
    } frame_t;

    // First-quarter sine in Q1.17 by an integer Taylor series (angle in Q30).
    // Evaluated at elaboration only, to fill the quarter-wave table.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j,
                                                      input int unsigned abits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] prod;
        logic [63:0] r;
        longint      sum;
        int          n;
        x    = (64'(j) * TWO_PI_Q30 + (64'd1 << (abits - 1))) >> abits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 8; n++)
        begin
            prod = (term * x2) >> 30;
            case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                7:       term = prod / 64'd210;
                default: term = prod / 64'd272;
            endcase
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (64'(sum) + 64'd4096) >> 13;
        if (r > SINE_ONE)
            r = SINE_ONE;
        return MAG_W'(r);
    endfunction

endpackage

// ----- src/stpg_front.sv -----
// stpg_front.sv - tick acceptance, phase and sample bookkeeping, quarter-wave
// sine lookup, gain and full-scale scaling. Depends on stpg_pkg.
module stpg_front
    import stpg_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 12,
    parameter int PHASE_BITS      = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              restart,
    input  cfg_t              cfg,
    input  logic [QCNT_W-1:0] queue_count,
    output logic              push,
    output frame_t            push_frame
);

    localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
    localparam int FOLD_W  = TABLE_ADDR_BITS - 1;
    localparam int OCC_W   = QCNT_W + 1;

    typedef struct packed {
        logic             neg;
        logic [NCH_W-1:0] nch;
        logic [NB_W-1:0]  nb;
        logic             done;
    } tag_t;

    // Quarter-wave table, entries 0 through QUARTER inclusive
    logic [MAG_W-1:0] rom [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_rom
        localparam logic [MAG_W-1:0] ENTRY = quarter_sine(g, TABLE_ADDR_BITS);
        assign rom[g] = ENTRY;
    end

    logic [PHASE_BITS-1:0]      acc_reg;
    logic [PHASE_BITS-1:0]      acc_next;
    logic [COUNT_W-1:0]         made_reg;
    logic [COUNT_W-1:0]         made_next;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       s2_valid_reg;
    logic                       s3_valid_reg;
    logic                       s4_valid_reg;
    logic                       s5_valid_reg;

    logic [FOLD_W-1:0]          s1_addr_reg;
    tag_t                       s1_tag_reg;
    logic [MAG_W-1:0]           s2_mag_reg;
    tag_t                       s2_tag_reg;
    logic [PROD_W-1:0]          s3_prod_reg;
    tag_t                       s3_tag_reg;
    logic [SAMPLE_W-1:0]        s4_mag_reg;
    tag_t                       s4_tag_reg;
    logic [SAMPLE_W-1:0]        s5_sample_reg;
    tag_t                       s5_tag_reg;

    logic                       accept;
    logic [PHASE_BITS-1:0]      phase_eff;
    logic [COUNT_W-1:0]         made_eff;
    logic                       live;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [FOLD_W-1:0]          fold;
    tag_t                       tag_in;
    logic [NCH_W-1:0]           nch_raw;
    logic [GAIN_W-1:0]          gain_c;
    logic [MAG_W+GAIN_W-1:0]    mult_full;
    logic [WIDE_W-1:0]          wide_p;
    logic [WIDE_W-1:0]          wide_shl;
    logic [WIDE_W-1:0]          wide_diff;
    logic [2:0]                 inflight;
    logic [OCC_W-1:0]           occupied;

    // Credit check: every frame in the pipe has a queue slot reserved
    assign inflight = 3'(s1_valid_reg) + 3'(s2_valid_reg) + 3'(s3_valid_reg)
                    + 3'(s4_valid_reg) + 3'(s5_valid_reg);
    assign occupied = OCC_W'(queue_count) + OCC_W'(inflight);
    assign s_tready = occupied < OCC_W'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    // Classify the tick: restart clears first, then a finished tone drops it
    always_comb
    begin
        phase_eff = restart ? '0 : acc_reg;
        made_eff  = restart ? '0 : made_reg;
        live      = made_eff < cfg.sample_count;
        acc_next  = acc_reg;
        made_next = made_reg;
        if (accept)
        begin
            acc_next  = live ? phase_eff + PHASE_BITS'(cfg.phase_inc) : phase_eff;
            made_next = live ? made_eff + COUNT_W'(1) : made_eff;
        end
        s1_valid_next = accept && live;
    end

    // Fold the full-cycle index onto the quarter table
    always_comb
    begin
        idx     = phase_eff[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        fold    = idx[TABLE_ADDR_BITS-2]
                ? FOLD_W'(QUARTER) - FOLD_W'(idx[TABLE_ADDR_BITS-3:0])
                : FOLD_W'(idx[TABLE_ADDR_BITS-3:0]);
        nch_raw = NCH_W'(cfg.channels);
        if (nch_raw == '0)
            tag_in.nch = NCH_W'(1);
        else if (nch_raw > NCH_W'(MAX_CHANNELS))
            tag_in.nch = NCH_W'(MAX_CHANNELS);
        else
            tag_in.nch = nch_raw;
        if (cfg.bytes == '0)
            tag_in.nb = NB_W'(1);
        else if (cfg.bytes > NB_W'(MAX_BYTES))
            tag_in.nb = NB_W'(MAX_BYTES);
        else
            tag_in.nb = cfg.bytes;
        tag_in.neg  = idx[TABLE_ADDR_BITS-1];
        tag_in.done = (made_eff + COUNT_W'(1)) == cfg.sample_count;
    end

    // Gain times sine magnitude
    assign gain_c    = (cfg.gain > GAIN_ONE) ? GAIN_ONE : cfg.gain;
    assign mult_full = {{GAIN_W{1'b0}}, s2_mag_reg} * {{MAG_W{1'b0}}, gain_c};

    // Times 2^(8*nb-1)-1 as a shift and a subtract, then drop 33 fraction bits
    always_comb
    begin
        wide_p = WIDE_W'(s3_prod_reg);
        case (s3_tag_reg.nb)
            NB_W'(1): wide_shl = wide_p << (BYTE_W - 1);
            NB_W'(2): wide_shl = wide_p << (2 * BYTE_W - 1);
            NB_W'(3): wide_shl = wide_p << (3 * BYTE_W - 1);
            default:  wide_shl = wide_p << (4 * BYTE_W - 1);
        endcase
        wide_diff = wide_shl - wide_p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            made_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg      <= acc_next;
            made_reg     <= made_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg   <= fold;
        s1_tag_reg    <= tag_in;
        s2_mag_reg    <= rom[s1_addr_reg];
        s2_tag_reg    <= s1_tag_reg;
        s3_prod_reg   <= mult_full[PROD_W-1:0];
        s3_tag_reg    <= s2_tag_reg;
        s4_mag_reg    <= wide_diff[SCALE_SHIFT +: SAMPLE_W];
        s4_tag_reg    <= s3_tag_reg;
        s5_sample_reg <= s4_tag_reg.neg ? SAMPLE_W'(0) - s4_mag_reg : s4_mag_reg;
        s5_tag_reg    <= s4_tag_reg;
    end

    assign push              = s5_valid_reg;
    assign push_frame.sample = s5_sample_reg;
    assign push_frame.nch    = s5_tag_reg.nch;
    assign push_frame.nb     = s5_tag_reg.nb;
    assign push_frame.done   = s5_tag_reg.done;

endmodule

// ----- src/stpg_fifo.sv -----
// stpg_fifo.sv - short frame queue between the sample front and the byte back.
// Depends on stpg_pkg.
module stpg_fifo
    import stpg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  frame_t            push_frame,
    input  logic              pop,
    output logic              head_valid,
    output frame_t            head,
    output logic [QCNT_W-1:0] count
);

    frame_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_frame;
    end

    assign head       = slots[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign count      = count_reg;

endmodule

// ----- src/stpg_back.sv -----
// stpg_back.sv - byte serializer: walks channels and bytes of the head frame
// into a registered output stage. Depends on stpg_pkg.
module stpg_back
    import stpg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  frame_t            head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic [USER_W-1:0] m_tuser,
    output logic              m_tlast
);

    logic [NCH_W-2:0]      ch_reg;
    logic [NCH_W-2:0]      ch_next;
    logic [BYTE_IDX_W-1:0] byte_reg;
    logic [BYTE_IDX_W-1:0] byte_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [BYTE_W-1:0]     data_reg;
    logic [USER_W-1:0]     user_reg;
    logic                  last_reg;

    logic                  load;
    logic                  last_byte;
    logic                  last_ch;
    logic [BYTE_W-1:0]     byte_sel;

    assign load      = head_valid && (!valid_reg || m_tready);
    assign last_byte = (NB_W'(byte_reg) + NB_W'(1)) == head.nb;
    assign last_ch   = (NCH_W'(ch_reg) + NCH_W'(1)) == head.nch;
    assign pop       = load && last_byte && last_ch;

    always_comb
    begin
        case (byte_reg)
            2'd0:    byte_sel = head.sample[0 * BYTE_W +: BYTE_W];
            2'd1:    byte_sel = head.sample[1 * BYTE_W +: BYTE_W];
            2'd2:    byte_sel = head.sample[2 * BYTE_W +: BYTE_W];
            default: byte_sel = head.sample[3 * BYTE_W +: BYTE_W];
        endcase
    end

    always_comb
    begin
        ch_next    = ch_reg;
        byte_next  = byte_reg;
        valid_next = valid_reg && !m_tready;
        if (load)
        begin
            valid_next = 1'b1;
            if (last_byte)
            begin
                byte_next = '0;
                ch_next   = last_ch ? '0 : ch_reg + (NCH_W-1)'(1);
            end
            else
            begin
                byte_next = byte_reg + BYTE_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg    <= '0;
            byte_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            ch_reg    <= ch_next;
            byte_reg  <= byte_next;
            valid_reg <= valid_next;
        end
    end

    // tuser: channel_index, byte_index, tone_done from the lowest bit up
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= byte_sel;
            user_reg <= {head.done, byte_reg, ch_reg[CH_IDX_W-1:0]};
            last_reg <= last_byte && last_ch;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- src/sine_tone_pcm_byte_generator_unit.sv -----
// sine_tone_pcm_byte_generator_unit.sv - top level: configuration registers and
// the front, queue and back of the generator. Depends on stpg_pkg, stpg_front,
// stpg_fifo and stpg_back.
//
// Usage: each transaction on the s_ side is one sample tick; s_tdata[0] is the
// restart flag, which clears the phase and the sample count before the tick's
// sample is made. A live tick makes one direct-synthesis sine sample, scaled by
// the gain and the sample width, and the m_ side carries it as
// channel_count * bytes_per_sample bytes, little-endian, channel by channel.
// m_tlast marks the last byte of a tick's frame; m_tuser carries the channel,
// the byte position and the tone-done flag. Ticks past sample_count make nothing.
//
// Path: the first byte of a frame reaches m_tvalid through front stages s1 to
// s5, the queue and the output register. The output serializer sends one byte
// per cycle while m_tready is high and a frame is queued; a frame is 1 to 32
// bytes. Ticks are taken every cycle while the eight-frame queue,
// counting the frames still in the front pipeline, has a free slot.
// Reset empties the pipeline and queue and loads the register defaults. When
// the receiver stalls, the output byte holds, the queue fills and s_tready drops.
// The configuration channel is always ready; write it only while idle.
module sine_tone_pcm_byte_generator_unit
    import stpg_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 12,
    parameter int PHASE_BITS      = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Tick input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,     // [0] restart
    // Byte output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,     // [7:0] data_byte
    output logic [USER_W-1:0]     m_tuser,     // [2:0] channel_index, [4:3] byte_index,
                                               // [5] tone_done
    output logic                  m_tlast,     // frame_last
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [PHASE_INC_W-1:0] phase_inc_reg;
    logic [PHASE_INC_W-1:0] phase_inc_next;
    logic [GAIN_W-1:0]      gain_reg;
    logic [GAIN_W-1:0]      gain_next;
    logic [CHCFG_W-1:0]     channels_reg;
    logic [CHCFG_W-1:0]     channels_next;
    logic [NBCFG_W-1:0]     bytes_reg;
    logic [NBCFG_W-1:0]     bytes_next;
    logic [COUNT_W-1:0]     sample_count_reg;
    logic [COUNT_W-1:0]     sample_count_next;

    cfg_t                   cfg;
    logic                   push;
    frame_t                 push_frame;
    logic                   pop;
    logic                   head_valid;
    frame_t                 head;
    logic [QCNT_W-1:0]      queue_count;

    assign cfg_ready = 1'b1;

    // Register write decode; unknown indexes drop the write
    always_comb
    begin
        phase_inc_next    = phase_inc_reg;
        gain_next         = gain_reg;
        channels_next     = channels_reg;
        bytes_next        = bytes_reg;
        sample_count_next = sample_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PHASE_INC:    phase_inc_next    = cfg_data[PHASE_INC_W-1:0];
                REG_GAIN:         gain_next         = cfg_data[GAIN_W-1:0];
                REG_CHANNELS:     channels_next     = cfg_data[CHCFG_W-1:0];
                REG_BYTES:        bytes_next        = cfg_data[NBCFG_W-1:0];
                REG_SAMPLE_COUNT: sample_count_next = cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg    <= '0;
            gain_reg         <= GAIN_ONE;
            channels_reg     <= CHCFG_W'(1);
            bytes_reg        <= NBCFG_W'(2);
            sample_count_reg <= '0;
        end
        else
        begin
            phase_inc_reg    <= phase_inc_next;
            gain_reg         <= gain_next;
            channels_reg     <= channels_next;
            bytes_reg        <= bytes_next;
            sample_count_reg <= sample_count_next;
        end
    end

    assign cfg.phase_inc    = phase_inc_reg;
    assign cfg.gain         = gain_reg;
    assign cfg.channels     = channels_reg;
    assign cfg.bytes        = bytes_reg;
    assign cfg.sample_count = sample_count_reg;

    // Front: take ticks, advance the oscillator, make scaled samples
    stpg_front #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .restart     (s_tdata[0]),
        .cfg         (cfg),
        .queue_count (queue_count),
        .push        (push),
        .push_frame  (push_frame)
    );

    // Queue: decouple sample production from byte delivery
    stpg_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (queue_count)
    );

    // Back: serialize each frame one byte per cycle while the receiver is ready
    stpg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- src/stpg_checker.sv -----
// stpg_checker.sv - port-level assertions for the sine tone PCM byte generator,
// bound to the top level. No package dependency.
module stpg_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [5:0] m_tuser,
    input logic       m_tlast
);

    // Hold a stalled byte
    a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    a_stall_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // A frame starts at channel 0, byte 0
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) ##1 m_tvalid |-> m_tuser[4:0] == 5'd0)
        else $error("frame did not start at channel 0 byte 0");

    // Tone-done flag is the same on every byte of a frame
    a_done_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |-> m_tuser[5] == $past(m_tuser[5]))
        else $error("tone_done changed inside a frame");

    // Inside a frame, advance the byte, or wrap it and advance the channel
    a_byte_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |->
            ((m_tuser[4:3] == $past(m_tuser[4:3]) + 2'd1)
                && (m_tuser[2:0] == $past(m_tuser[2:0])))
            || ((m_tuser[4:3] == 2'd0)
                && (m_tuser[2:0] == $past(m_tuser[2:0]) + 3'd1)))
        else $error("bytes of a frame out of order");

endmodule

bind sine_tone_pcm_byte_generator_unit stpg_checker u_stpg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
